### hdl/scba_pkg.sv
// Shared types, constants and status codes of the size-class block allocator.
`timescale 1ns / 1ps
package scba_pkg;

    localparam int CLASS_COUNT    = 7;
    localparam int SMALLEST_BLOCK = 64;
    localparam int LOG_SMALLEST   = 6;
    localparam int PAGE_BYTES     = 4096;
    localparam int PAGE_LOG       = 12;
    localparam int MAX_PAGES      = 64;
    localparam int MAX_BLOCK      = SMALLEST_BLOCK << (CLASS_COUNT - 1);

    localparam int CLS_W          = 3;
    localparam int SIZE_W         = 32;
    localparam int ADDR_IN_W      = 32;
    localparam int ADDR_W         = 31;
    localparam int STATUS_W       = 3;
    localparam int LIMIT_W        = 7;
    localparam int REGION_LSB     = 28;
    // Offsets of carved blocks inside a class region stay below 64 pages.
    localparam int OFF_W          = 18;
    localparam int CUR_W          = OFF_W + 1;
    localparam int BLK_W          = 12;
    localparam int LINK_IDX_W     = CLS_W + BLK_W;
    localparam int LINK_DEPTH     = CLASS_COUNT * (1 << BLK_W);
    localparam int LINK_W         = OFF_W + 1;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = 1;
    localparam int QCNT_W         = 2;

    localparam logic [STATUS_W-1:0] ST_ALLOC   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OUT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LARGE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_LARGE,
        OP_IGNORE
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CLS_W-1:0] cls;
        logic [OFF_W-1:0] off;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_out_t;

    typedef enum logic {
        BK_IDLE,
        BK_POP
    } back_state_t;

endpackage

### hdl/scba_front.sv
// Front end: accepts an item and classifies it into an operation, size class and offset.
`timescale 1ns / 1ps
module scba_front
(
    input  logic                             start,
    input  logic                             full,
    input  logic                             cmd,
    input  logic [scba_pkg::SIZE_W-1:0]      req_size,
    input  logic [scba_pkg::ADDR_IN_W-1:0]   free_addr,
    output logic                             push,
    output scba_pkg::item_t                  item
);

    logic [scba_pkg::CLS_W-1:0]      alloc_cls;
    logic [3:0]                      region;
    logic [scba_pkg::CLS_W-1:0]      free_cls;
    logic [scba_pkg::REGION_LSB-1:0] aligned;
    logic                            region_ok;

    assign push = start && !full;

    // Smallest class that fits; scanning downward leaves the smallest match.
    always_comb
    begin
        alloc_cls = scba_pkg::CLS_W'(scba_pkg::CLASS_COUNT - 1);
        for (int i = scba_pkg::CLASS_COUNT - 2; i >= 0; i--)
        begin
            if (req_size <= (scba_pkg::SIZE_W'(scba_pkg::SMALLEST_BLOCK) << i))
            begin
                alloc_cls = scba_pkg::CLS_W'(i);
            end
        end
    end

    assign region    = free_addr[scba_pkg::ADDR_IN_W-1:scba_pkg::REGION_LSB];
    assign free_cls  = scba_pkg::CLS_W'(region - 4'd1);
    assign region_ok = !region[3] && (region[2:0] != 3'd0);
    assign aligned   = free_addr[scba_pkg::REGION_LSB-1:0]
                     & ~((scba_pkg::REGION_LSB'(scba_pkg::SMALLEST_BLOCK) << free_cls)
                         - scba_pkg::REGION_LSB'(1));

    always_comb
    begin
        item.op  = scba_pkg::OP_ALLOC;
        item.cls = alloc_cls;
        item.off = '0;
        if (cmd == scba_pkg::CMD_ALLOC)
        begin
            if (req_size > scba_pkg::SIZE_W'(scba_pkg::MAX_BLOCK))
            begin
                item.op = scba_pkg::OP_LARGE;
            end
        end
        else
        begin
            item.cls = free_cls;
            item.off = aligned[scba_pkg::OFF_W-1:0];
            // Anything beyond the largest carvable offset was never carved.
            if (!region_ok || (aligned[scba_pkg::REGION_LSB-1:scba_pkg::OFF_W] != '0))
            begin
                item.op = scba_pkg::OP_IGNORE;
            end
            else
            begin
                item.op = scba_pkg::OP_FREE;
            end
        end
    end

endmodule

### hdl/scba_queue.sv
// Two-entry queue of classified items between the front end and the back end.
`timescale 1ns / 1ps
module scba_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  scba_pkg::item_t         push_item,
    input  logic                    pop,
    output logic                    full,
    output scba_pkg::queue_out_t    head
);

    scba_pkg::item_t                  entry_reg [scba_pkg::QUEUE_DEPTH];
    logic [scba_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [scba_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [scba_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [scba_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [scba_pkg::QCNT_W-1:0]      count_reg;
    logic [scba_pkg::QCNT_W-1:0]      count_next;
    logic                             do_pop;

    assign full       = (count_reg == scba_pkg::QCNT_W'(scba_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + scba_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + scba_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + scba_pkg::QCNT_W'(push) - scba_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/scba_back.sv
// Back end: free-list heads, carve cursors and link memory; executes one item at a time.
`timescale 1ns / 1ps
module scba_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [scba_pkg::LIMIT_W-1:0]        page_limit,
    input  scba_pkg::queue_out_t                head,
    output logic                                pop,
    output logic                                done,
    output logic [scba_pkg::ADDR_W-1:0]         alloc_addr,
    output logic [scba_pkg::STATUS_W-1:0]       status
);

    scba_pkg::back_state_t            state_reg;
    scba_pkg::back_state_t            state_next;

    logic                             head_valid_reg [scba_pkg::CLASS_COUNT];
    logic                             head_valid_next [scba_pkg::CLASS_COUNT];
    logic [scba_pkg::OFF_W-1:0]       head_off_reg [scba_pkg::CLASS_COUNT];
    logic [scba_pkg::OFF_W-1:0]       head_off_next [scba_pkg::CLASS_COUNT];
    logic [scba_pkg::CUR_W-1:0]       cursor_reg [scba_pkg::CLASS_COUNT];
    logic [scba_pkg::CUR_W-1:0]       cursor_next [scba_pkg::CLASS_COUNT];

    logic [scba_pkg::LINK_W-1:0]      link_mem [scba_pkg::LINK_DEPTH];
    logic [scba_pkg::LINK_W-1:0]      link_rdata_reg;
    logic                             link_rd;
    logic                             link_wr;
    logic [scba_pkg::LINK_IDX_W-1:0]  link_idx;
    logic [scba_pkg::LINK_W-1:0]      link_wdata;

    logic [scba_pkg::CLS_W-1:0]       pend_cls_reg;
    logic [scba_pkg::CLS_W-1:0]       pend_cls_next;
    logic [scba_pkg::OFF_W-1:0]       pend_off_reg;
    logic [scba_pkg::OFF_W-1:0]       pend_off_next;

    logic                             done_reg;
    logic                             done_next;
    logic [scba_pkg::ADDR_W-1:0]      addr_reg;
    logic [scba_pkg::ADDR_W-1:0]      addr_next;
    logic [scba_pkg::STATUS_W-1:0]    status_reg;
    logic [scba_pkg::STATUS_W-1:0]    status_next;

    logic [scba_pkg::LIMIT_W-1:0]     limit;
    logic [scba_pkg::CUR_W-1:0]       limit_bytes;
    logic [scba_pkg::CLS_W-1:0]       cls;
    logic [scba_pkg::OFF_W-1:0]       sel_off;
    logic [scba_pkg::CUR_W-1:0]       block_bytes;

    assign done       = done_reg;
    assign alloc_addr = addr_reg;
    assign status     = status_reg;

    assign limit       = (page_limit > scba_pkg::LIMIT_W'(scba_pkg::MAX_PAGES))
                       ? scba_pkg::LIMIT_W'(scba_pkg::MAX_PAGES) : page_limit;
    assign limit_bytes = {limit, {scba_pkg::PAGE_LOG{1'b0}}};
    assign cls         = head.item.cls;
    assign block_bytes = scba_pkg::CUR_W'(scba_pkg::SMALLEST_BLOCK) << cls;

    // A pop links from the current head, a free links at the freed block.
    assign sel_off  = (head.item.op == scba_pkg::OP_FREE) ? head.item.off : head_off_reg[cls];
    assign link_idx = {cls, scba_pkg::BLK_W'(sel_off >> (scba_pkg::LOG_SMALLEST + 32'(cls)))};

    function automatic logic [scba_pkg::ADDR_W-1:0] make_addr(
        input logic [scba_pkg::CLS_W-1:0] c,
        input logic [scba_pkg::OFF_W-1:0] off
    );
        make_addr = {scba_pkg::CLS_W'(c + scba_pkg::CLS_W'(1)),
                     {(scba_pkg::REGION_LSB - scba_pkg::OFF_W){1'b0}}, off};
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        head_valid_next = head_valid_reg;
        head_off_next   = head_off_reg;
        cursor_next     = cursor_reg;
        pend_cls_next   = pend_cls_reg;
        pend_off_next   = pend_off_reg;
        done_next       = 1'b0;
        addr_next       = '0;
        status_next     = status_reg;
        pop             = 1'b0;
        link_rd         = 1'b0;
        link_wr         = 1'b0;
        link_wdata      = {head_valid_reg[cls], head_off_reg[cls]};

        case (state_reg)
            scba_pkg::BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    case (head.item.op)
                        scba_pkg::OP_ALLOC:
                        begin
                            if (head_valid_reg[cls])
                            begin
                                // Successor comes back from link memory next cycle.
                                link_rd       = 1'b1;
                                pend_cls_next = cls;
                                pend_off_next = head_off_reg[cls];
                                state_next    = scba_pkg::BK_POP;
                            end
                            else if (cursor_reg[cls] >= limit_bytes)
                            begin
                                done_next   = 1'b1;
                                status_next = scba_pkg::ST_OUT;
                            end
                            else
                            begin
                                done_next        = 1'b1;
                                status_next      = scba_pkg::ST_ALLOC;
                                addr_next        = make_addr(cls,
                                                   cursor_reg[cls][scba_pkg::OFF_W-1:0]);
                                cursor_next[cls] = cursor_reg[cls] + block_bytes;
                            end
                        end
                        scba_pkg::OP_FREE:
                        begin
                            done_next = 1'b1;
                            if ({1'b0, head.item.off} >= cursor_reg[cls])
                            begin
                                status_next = scba_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                link_wr              = 1'b1;
                                head_valid_next[cls] = 1'b1;
                                head_off_next[cls]   = head.item.off;
                                status_next          = scba_pkg::ST_FREED;
                            end
                        end
                        scba_pkg::OP_LARGE:
                        begin
                            done_next   = 1'b1;
                            status_next = scba_pkg::ST_LARGE;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = scba_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end
            scba_pkg::BK_POP:
            begin
                head_valid_next[pend_cls_reg] = link_rdata_reg[scba_pkg::LINK_W-1];
                head_off_next[pend_cls_reg]   = link_rdata_reg[scba_pkg::OFF_W-1:0];
                done_next                     = 1'b1;
                status_next                   = scba_pkg::ST_ALLOC;
                addr_next                     = make_addr(pend_cls_reg, pend_off_reg);
                state_next                    = scba_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = scba_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= scba_pkg::BK_IDLE;
            done_reg   <= 1'b0;
            status_reg <= scba_pkg::ST_ALLOC;
            for (int i = 0; i < scba_pkg::CLASS_COUNT; i++)
            begin
                head_valid_reg[i] <= 1'b0;
                cursor_reg[i]     <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            head_valid_reg <= head_valid_next;
            cursor_reg     <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_off_reg <= head_off_next;
        pend_cls_reg <= pend_cls_next;
        pend_off_reg <= pend_off_next;
        addr_reg     <= addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (link_wr)
        begin
            link_mem[link_idx] <= link_wdata;
        end
        if (link_rd)
        begin
            link_rdata_reg <= link_mem[link_idx];
        end
    end

endmodule

### hdl/size_class_block_allocator.sv
// Top level of the size-class block allocator: config register, front end, queue, back end.
//
// Usage: drive cmd, req_size and free_addr with start high; the item is taken at
// a clock edge where start is high and busy is low. busy rises when the
// two-entry item queue is full. Each item gives one result: done is high for
// exactly one cycle with alloc_addr and status, and the receiver cannot stall.
// Results come out in item order.
// Between acceptance and done an item passes the queue entry and the result
// register when the back end is free; an allocation served from a free list
// also passes the registered link memory read of the next head.
// Throughput: one item per cycle, except that a free-list pop holds the back
// end on that link memory read. The user must assert cfg_we, which writes
// page_limit from cfg_wdata, only while the block is idle; the block itself
// does not enforce this. Reset empties every free list, returns each carve
// cursor to its region base and sets page_limit to 64. The link memory is not
// cleared; an entry is always written before it can be read.
`timescale 1ns / 1ps
module size_class_block_allocator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic [scba_pkg::SIZE_W-1:0]       req_size,
    input  logic [scba_pkg::ADDR_IN_W-1:0]    free_addr,
    input  logic                              cfg_we,
    input  logic [scba_pkg::LIMIT_W-1:0]      cfg_wdata,
    output logic                              done,
    output logic [scba_pkg::ADDR_W-1:0]       alloc_addr,
    output logic [scba_pkg::STATUS_W-1:0]     status
);

    logic [scba_pkg::LIMIT_W-1:0]  page_limit_reg;
    logic [scba_pkg::LIMIT_W-1:0]  page_limit_next;
    logic                          push;
    logic                          pop;
    logic                          full;
    scba_pkg::item_t               push_item;
    scba_pkg::queue_out_t          q_head;

    assign busy            = full;
    assign page_limit_next = cfg_we ? cfg_wdata : page_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_limit_reg <= scba_pkg::LIMIT_W'(scba_pkg::MAX_PAGES);
        end
        else
        begin
            page_limit_reg <= page_limit_next;
        end
    end

    scba_front u_front
    (
        .start     (start),
        .full      (full),
        .cmd       (cmd),
        .req_size  (req_size),
        .free_addr (free_addr),
        .push      (push),
        .item      (push_item)
    );

    scba_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (full),
        .head      (q_head)
    );

    scba_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .page_limit (page_limit_reg),
        .head       (q_head),
        .pop        (pop),
        .done       (done),
        .alloc_addr (alloc_addr),
        .status     (status)
    );

    // Only a successful allocation carries an address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != scba_pkg::ST_ALLOC)) |-> (alloc_addr == '0))
        else $error("address given with a non-allocating status");

    // An allocated block always lies inside one of the class regions.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == scba_pkg::ST_ALLOC))
            |-> (alloc_addr[scba_pkg::ADDR_W-1:scba_pkg::REGION_LSB] != '0))
        else $error("allocated block outside the class regions");

    // The queue only fills up after an accepted item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted item");

    // A result never appears in the cycle right after reset is released.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !done)
        else $error("result without a preceding item");

endmodule
